// ----- hdl/gds_pkg.sv -----
// shared types and constants for the graph diffusion step block
`default_nettype none
package gds_pkg;
    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_STEP = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;
    localparam int unsigned VAL_W  = 32;
    localparam int unsigned NB_W   = 10;
    localparam int unsigned NB_MAX = 6;
    localparam int unsigned CNT_W  = 11;
    localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;
    localparam logic [1:0] REG_NUM_VERTS = 2'd0;
    typedef struct packed {
        logic       start;
        logic [63:0] radicand;
    } t_sqrt_req;
    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } t_sqrt_rsp;
endpackage
`default_nettype wire

// ----- hdl/gds_sqrt.sv -----
// bit-serial integer square root of a 64-bit radicand, one result bit per cycle
`default_nettype none
module gds_sqrt (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire gds_pkg::t_sqrt_req i_req,
    output gds_pkg::t_sqrt_rsp      o_rsp
);
    logic [63:0] r_rem;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic        r_busy;
    logic        r_done;
    logic [63:0] w_trial;

    assign w_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rem  <= i_req.radicand;
                r_res  <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
            end else if (r_busy) begin
                if (r_rem >= w_trial) begin
                    r_rem <= r_rem - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_res[31:0];
endmodule
`default_nettype wire

// ----- hdl/graph_diffusion_step_top.sv -----
// top level of the graph diffusion step block
//
// Commands enter on start with i_cmd and the payload; a transfer happens when
// start is high and busy is low. Each transfer gives one result on o_result_*
// marked by o_result_valid for one cycle, except cmd 3 which is dropped silently.
// A load writes the vertex at its transfer and shows its acknowledge in the next
// cycle without raising busy. A read of an index below MAX_VERTS raises busy for
// S_READ, where its data is registered, and shows it in the cycle busy drops.
// A step over n active vertices holds busy and shows its result in the cycle
// busy drops: pass 1 rescales each value (S_P1_RD, S_P1_WR), pass 2 reads
// each vertex and read-modify-writes those of its six neighbours inside the
// active set (S_P2_RD, S_P2_NB, then S_P2_NBWAIT, S_P2_NBWR per neighbour),
// pass 3 accumulates squared changes (S_P3_RD, S_P3_ACC, S_P3_SQ, S_SQRT_WAIT),
// each pass ends in its read state, and the serial square root runs in S_SQRT.
// Reset clears the control state, the sum, the sticky flag and sets the
// vertex count to its reset value; reset does not clear the memories.
// The user configures via the APB port only while idle; the block does not check.
// Results cannot be held off: the receiver takes each one in its cycle.
`default_nettype none
module graph_diffusion_step_top #(
    parameter int unsigned MAX_VERTS = 1024,
    parameter int unsigned DEGREE    = 6
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [1:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  i_cmd,
    input  wire  [9:0]  i_vertex_index,
    input  wire  signed [31:0] i_vertex_value,
    input  wire  [9:0]  i_neighbour_0,
    input  wire  [9:0]  i_neighbour_1,
    input  wire  [9:0]  i_neighbour_2,
    input  wire  [9:0]  i_neighbour_3,
    input  wire  [9:0]  i_neighbour_4,
    input  wire  [9:0]  i_neighbour_5,
    output logic        o_result_valid,
    output logic [1:0]  o_result_kind,
    output logic signed [31:0] o_read_value,
    output logic [31:0] o_step_norm,
    output logic        o_saturated
);
    localparam int unsigned AW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
    localparam int unsigned NW = 60;
    localparam logic [20:0] MAXV = 21'(MAX_VERTS);
    localparam logic [2:0] DEG_LAST = 3'(DEGREE - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_P1_RD, S_P1_WR, S_P2_RD, S_P2_NB, S_P2_NBWAIT,
        S_P2_NBWR, S_P3_RD, S_P3_ACC, S_P3_SQ, S_SQRT, S_SQRT_WAIT
    } t_state;

    logic [31:0] r_value_mem [MAX_VERTS];
    logic [31:0] r_old_mem   [MAX_VERTS];
    logic [NW-1:0] r_nb_mem  [MAX_VERTS];

    t_state r_state;
    logic [10:0] r_num;
    logic [20:0] r_n;
    logic [20:0] r_v;
    logic [2:0]  r_k;
    logic [AW-1:0] r_vaddr;
    logic [31:0] r_vrd;
    logic [31:0] r_ord;
    logic [NW-1:0] r_nbrd;
    logic signed [31:0] r_share;
    logic signed [32:0] r_diff;
    logic [63:0] r_sum;
    logic [63:0] r_sq;
    logic        r_sat;
    logic        r_vld;
    logic [1:0]  r_kind;
    logic [31:0] r_rd;
    logic [31:0] r_norm;
    logic        r_sqrt_go;

    gds_pkg::t_sqrt_req w_req;
    gds_pkg::t_sqrt_rsp w_rsp;

    logic [9:0]  w_tgt;
    logic signed [32:0] w_add;
    logic [64:0] w_acc;
    logic [31:0] w_div;
    logic signed [31:0] w_ordiv;
    logic [32:0] w_mag;

    function automatic logic [31:0] div7(input logic signed [31:0] a);
        logic [31:0] m;
        logic [63:0] p;
        logic [31:0] q;
        m = a[31] ? 32'(-a) : 32'(a);
        p = 64'(m) * 64'h0000_0000_9249_2493;
        q = 32'(p >> 34);
        if (32'(m - q * 32'd7) >= 32'd7) q = q + 32'd1;
        div7 = a[31] ? 32'(-q) : q;
    endfunction

    assign w_div   = div7(r_vrd);
    assign w_ordiv = div7(r_ord);
    assign w_tgt   = r_nbrd[r_k*10 +: 10];
    assign w_add   = 33'(signed'(r_vrd)) + 33'(r_share);
    assign w_mag   = r_diff[32] ? 33'(-r_diff) : 33'(r_diff);
    assign w_acc   = 65'(r_sum) + 65'(r_sq);

    assign w_req.start    = r_sqrt_go;
    assign w_req.radicand = r_sum;

    gds_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    assign pready = 1'b1;
    assign prdata = (paddr == gds_pkg::REG_NUM_VERTS) ? 32'(r_num) : 32'd0;
    assign busy   = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (start && !busy && i_cmd == gds_pkg::CMD_LOAD
                && 21'(i_vertex_index) < MAXV) begin
            r_value_mem[i_vertex_index[AW-1:0]] <= i_vertex_value;
            r_old_mem[i_vertex_index[AW-1:0]]   <= '0;
            r_nb_mem[i_vertex_index[AW-1:0]] <= {i_neighbour_5, i_neighbour_4,
                i_neighbour_3, i_neighbour_2, i_neighbour_1, i_neighbour_0};
        end else if (r_state == S_P1_WR) begin
            r_value_mem[r_vaddr] <= w_div;
            r_old_mem[r_vaddr]   <= r_vrd;
        end else if (r_state == S_P2_NBWR && 21'(w_tgt) < r_n) begin
            r_value_mem[r_vaddr] <= (w_add > 33'sh0_7FFF_FFFF) ? 32'h7FFF_FFFF :
                (w_add < -33'sh0_8000_0000) ? 32'h8000_0000 : w_add[31:0];
        end
        r_vrd  <= r_value_mem[r_vaddr];
        r_ord  <= r_old_mem[r_vaddr];
        if (r_state == S_P2_RD)
            r_nbrd <= r_nb_mem[r_vaddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_num     <= gds_pkg::CNT_RESET;
            r_sum     <= '0;
            r_sat     <= 1'b0;
            r_vld     <= 1'b0;
            r_sqrt_go <= 1'b0;
        end else begin
            r_vld     <= 1'b0;
            r_sqrt_go <= 1'b0;
            if (psel && penable && pwrite && paddr == gds_pkg::REG_NUM_VERTS)
                r_num <= pwdata[10:0];
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_vaddr <= i_vertex_index[AW-1:0];
                        r_rd    <= '0;
                        r_norm  <= '0;
                        r_v     <= '0;
                        r_n     <= (21'(r_num) > MAXV) ? MAXV : 21'(r_num);
                        unique case (i_cmd)
                            gds_pkg::CMD_LOAD: begin
                                r_vld  <= 1'b1;
                                r_kind <= gds_pkg::CMD_LOAD;
                            end
                            gds_pkg::CMD_STEP: begin
                                r_vaddr <= '0;
                                r_state <= S_P1_RD;
                            end
                            gds_pkg::CMD_READ: begin
                                r_state <= (21'(i_vertex_index) < MAXV) ? S_READ : S_IDLE;
                                if (21'(i_vertex_index) >= MAXV) begin
                                    r_vld  <= 1'b1;
                                    r_kind <= gds_pkg::CMD_READ;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_IDLE;
                    r_vld   <= 1'b1;
                    r_kind  <= gds_pkg::CMD_READ;
                    r_rd    <= r_value_mem[r_vaddr];
                end
                S_P1_RD: begin
                    if (r_v >= r_n) begin
                        r_v     <= '0;
                        r_vaddr <= '0;
                        r_state <= S_P2_RD;
                    end else begin
                        r_state <= S_P1_WR;
                    end
                end
                S_P1_WR: begin
                    r_v     <= r_v + 21'd1;
                    r_vaddr <= r_vaddr + AW'(1);
                    r_state <= S_P1_RD;
                end
                S_P2_RD: begin
                    if (r_v >= r_n) begin
                        r_v     <= '0;
                        r_vaddr <= '0;
                        r_sum   <= '0;
                        r_state <= S_P3_RD;
                    end else begin
                        r_k     <= '0;
                        r_state <= S_P2_NB;
                    end
                end
                S_P2_NB: begin
                    r_share <= w_ordiv;
                    r_vaddr <= w_tgt[AW-1:0];
                    r_state <= S_P2_NBWAIT;
                end
                S_P2_NBWAIT: r_state <= S_P2_NBWR;
                S_P2_NBWR: begin
                    if (21'(w_tgt) < r_n &&
                        (w_add > 33'sh0_7FFF_FFFF || w_add < -33'sh0_8000_0000))
                        r_sat <= 1'b1;
                    if (r_k == DEG_LAST) begin
                        r_v     <= r_v + 21'd1;
                        r_vaddr <= AW'(r_v + 21'd1);
                        r_state <= S_P2_RD;
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_vaddr <= r_nbrd[(r_k+3'd1)*10 +: AW];
                        r_state <= S_P2_NBWAIT;
                    end
                end
                S_P3_RD: begin
                    if (r_v >= r_n) begin
                        r_sqrt_go <= 1'b1;
                        r_state   <= S_SQRT;
                    end else begin
                        r_state <= S_P3_ACC;
                    end
                end
                S_P3_ACC: begin
                    r_diff  <= 33'(signed'(r_ord)) - 33'(signed'(r_vrd));
                    r_state <= S_P3_SQ;
                end
                S_P3_SQ: begin
                    r_sq    <= 64'(w_mag) * 64'(w_mag);
                    r_v     <= r_v + 21'd1;
                    r_vaddr <= r_vaddr + AW'(1);
                    r_state <= S_SQRT_WAIT;
                end
                S_SQRT_WAIT: begin
                    if (w_acc[64]) begin
                        r_sum <= '1;
                        r_sat <= 1'b1;
                    end else begin
                        r_sum <= w_acc[63:0];
                    end
                    r_state <= S_P3_RD;
                end
                S_SQRT: begin
                    if (w_rsp.done) begin
                        r_norm  <= w_rsp.root;
                        r_vld   <= 1'b1;
                        r_kind  <= gds_pkg::CMD_STEP;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result_valid = r_vld;
    assign o_result_kind  = r_kind;
    assign o_read_value   = r_rd;
    assign o_step_norm    = r_norm;
    assign o_saturated    = r_sat;
endmodule
`default_nettype wire

// ----- hdl/gds_checker.sv -----
// port-level checks for the graph diffusion step block
`default_nettype none
module gds_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        busy,
    input wire        o_result_valid,
    input wire [1:0]  o_result_kind,
    input wire [31:0] o_read_value,
    input wire [31:0] o_step_norm,
    input wire        o_saturated,
    input wire        pready
);
    a_flag_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_saturated |=> o_saturated) else $error("saturation flag dropped");
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy) else $error("result while busy");
    a_read_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result_kind != 2'd1) |-> o_step_norm == 32'd0)
        else $error("norm on non-step result");
    a_load_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result_kind == 2'd0) |-> o_read_value == 32'd0)
        else $error("read data on load ack");
    a_ready: assert property (@(posedge i_clk) pready) else $error("pready low");
endmodule

bind graph_diffusion_step_top gds_checker u_gds_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .busy(busy),
    .o_result_valid(o_result_valid), .o_result_kind(o_result_kind),
    .o_read_value(o_read_value), .o_step_norm(o_step_norm),
    .o_saturated(o_saturated), .pready(pready)
);
`default_nettype wire

// ----- tb/graph_diffusion_step_top_tb.sv -----
// testbench for graph_diffusion_step_top: predicted results checked per transfer
`timescale 1ns / 1ps
module graph_diffusion_step_top_tb;

    typedef struct {
        gds_pkg::t_cmd cmd;
        logic [9:0]  idx;
        logic [31:0] val;
        logic [9:0]  nb [6];
    } t_item;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] rd;
        logic [31:0] norm;
        logic        sat;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_cmd = '0;
    logic [9:0]  i_vertex_index = '0;
    logic signed [31:0] i_vertex_value = '0;
    logic [9:0]  i_nb [6] = '{default: '0};
    logic        o_result_valid;
    logic [1:0]  o_result_kind;
    logic signed [31:0] o_read_value;
    logic [31:0] o_step_norm;
    logic        o_saturated;

    t_item       pending_items [$];
    t_result     expected_results [$];
    int unsigned accepted_cnt = 0;
    int unsigned issued_cnt = 0;
    bit          failed = 1'b0;

    logic signed [31:0] vert_val [1024];
    logic signed [31:0] vert_old [1024];
    logic [9:0]         vert_nb [1024][6];
    bit                 sat_flag = 1'b0;
    logic [10:0]        active_cnt = gds_pkg::CNT_RESET;

    graph_diffusion_step_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .i_cmd(i_cmd),
        .i_vertex_index(i_vertex_index), .i_vertex_value(i_vertex_value),
        .i_neighbour_0(i_nb[0]), .i_neighbour_1(i_nb[1]), .i_neighbour_2(i_nb[2]),
        .i_neighbour_3(i_nb[3]), .i_neighbour_4(i_nb[4]), .i_neighbour_5(i_nb[5]),
        .o_result_valid(o_result_valid), .o_result_kind(o_result_kind),
        .o_read_value(o_read_value), .o_step_norm(o_step_norm),
        .o_saturated(o_saturated)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] root64(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res[31:0];
    endfunction

    function automatic logic signed [31:0] add_sat(longint a);
        if (a > 64'sd2147483647) begin
            sat_flag = 1'b1;
            return 32'sh7fffffff;
        end
        if (a < -64'sd2147483648) begin
            sat_flag = 1'b1;
            return 32'sh80000000;
        end
        return a[31:0];
    endfunction

    function automatic logic [31:0] diffuse_norm();
        int          n;
        longint      share;
        longint      d;
        logic [63:0] sq;
        logic [63:0] acc;
        n = (active_cnt > 1024) ? 1024 : int'(active_cnt);
        for (int v = 0; v < n; v++) begin
            vert_old[v] = vert_val[v];
            vert_val[v] = 32'(longint'(vert_val[v]) / 7);
        end
        for (int v = 0; v < n; v++) begin
            share = longint'(vert_old[v]) / 7;
            for (int k = 0; k < 6; k++)
                if (int'(vert_nb[v][k]) < n)
                    vert_val[vert_nb[v][k]] = add_sat(longint'(vert_val[vert_nb[v][k]]) + share);
        end
        acc = 0;
        for (int v = 0; v < n; v++) begin
            d = longint'(vert_old[v]) - longint'(vert_val[v]);
            if (d < 0) d = -d;
            sq = 64'(d) * 64'(d);
            if (acc > ~64'd0 - sq) begin
                acc = ~64'd0;
                sat_flag = 1'b1;
            end else begin
                acc = acc + sq;
            end
        end
        return root64(acc);
    endfunction

    function automatic void predict(t_item it);
        t_result r;
        r.rd = 0;
        r.norm = 0;
        case (it.cmd)
            gds_pkg::CMD_LOAD: begin
                vert_val[it.idx] = it.val;
                vert_old[it.idx] = 0;
                for (int k = 0; k < 6; k++) vert_nb[it.idx][k] = it.nb[k];
                r.kind = gds_pkg::CMD_LOAD;
            end
            gds_pkg::CMD_STEP: begin
                r.norm = diffuse_norm();
                r.kind = gds_pkg::CMD_STEP;
            end
            gds_pkg::CMD_READ: begin
                r.rd = vert_val[it.idx];
                r.kind = gds_pkg::CMD_READ;
            end
            default: return;
        endcase
        r.sat = sat_flag;
        expected_results.push_back(r);
    endfunction

    // driver
    always @(negedge i_clk) begin
        t_item it;
        if (start && accepted_cnt != issued_cnt) begin
            // held until the transfer happens
        end else if (i_rst_n && pending_items.size() > 0
                     && ((accepted_cnt > 60 && accepted_cnt < 110)
                         || $urandom_range(99) >= 29)) begin
            it = pending_items.pop_front();
            start <= 1'b1;
            i_cmd <= it.cmd;
            i_vertex_index <= it.idx;
            i_vertex_value <= it.val;
            for (int k = 0; k < 6; k++) i_nb[k] <= it.nb[k];
            issued_cnt <= issued_cnt + 1;
        end else begin
            start <= 1'b0;
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        t_item   it;
        t_result e;
        if (o_result_valid) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result kind %0d", $time, o_result_kind);
                failed = 1'b1;
            end else begin
                e = expected_results.pop_front();
                if (o_result_kind !== e.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $time, e.kind, o_result_kind);
                    failed = 1'b1;
                end
                if (o_read_value !== e.rd) begin
                    $display("%0t: read_value expected %h actual %h", $time, e.rd, o_read_value);
                    failed = 1'b1;
                end
                if (o_step_norm !== e.norm) begin
                    $display("%0t: step_norm expected %h actual %h", $time, e.norm, o_step_norm);
                    failed = 1'b1;
                end
                if (o_saturated !== e.sat) begin
                    $display("%0t: saturated expected %0d actual %0d", $time, e.sat, o_saturated);
                    failed = 1'b1;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            it.cmd = gds_pkg::t_cmd'(i_cmd);
            it.idx = i_vertex_index;
            it.val = i_vertex_value;
            for (int k = 0; k < 6; k++) it.nb[k] = i_nb[k];
            predict(it);
            accepted_cnt <= accepted_cnt + 1;
        end
    end

    task automatic reg_write(logic [10:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= gds_pkg::REG_NUM_VERTS;
        pwdata <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        active_cnt = value;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain(int unsigned settle);
        wait (pending_items.size() == 0 && !start && expected_results.size() == 0);
        repeat (settle) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(2000)) - 1000) <<< 20;
            2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(65535)) - 32768) <<< 16;
        endcase
    endfunction

    function automatic void queue_item(gds_pkg::t_cmd c, int idx, logic [31:0] val,
                                       int nbmax);
        t_item it;
        it.cmd = c;
        it.idx = idx[9:0];
        it.val = val;
        for (int k = 0; k < 6; k++)
            it.nb[k] = (nbmax >= 1023) ? 10'($urandom()) : 10'($urandom_range(nbmax));
        pending_items.push_back(it);
    endfunction

    function automatic void queue_load(int idx, logic [31:0] val, int n0, int n1, int n2,
                                       int n3, int n4, int n5);
        t_item it;
        it.cmd = gds_pkg::CMD_LOAD;
        it.idx = idx[9:0];
        it.val = val;
        it.nb = '{n0[9:0], n1[9:0], n2[9:0], n3[9:0], n4[9:0], n5[9:0]};
        pending_items.push_back(it);
    endfunction

    initial begin
        int n;
        int r;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, self loops, shares dropped outside the active set
        reg_write(11'd4);
        queue_load(0, 32'h7fffffff, 1, 1, 1, 1, 1, 1);
        queue_load(1, 32'h80000000, 0, 2, 3, 1, 1023, 0);
        queue_load(2, 32'h00000000, 1023, 1023, 1023, 1023, 1023, 1023);
        queue_load(3, 32'hffffffff, 3, 3, 3, 3, 3, 3);
        queue_load(1023, 32'h01000000, 682, 341, 0, 0, 0, 0);
        queue_item(gds_pkg::CMD_READ, 0, 0, 0);
        queue_item(gds_pkg::CMD_READ, 1023, 0, 0);
        queue_item(gds_pkg::CMD_NONE, 5, 32'h12345678, 1023);
        queue_item(gds_pkg::CMD_STEP, 0, 0, 0);
        for (int v = 0; v < 4; v++) queue_item(gds_pkg::CMD_READ, v, 0, 0);
        queue_item(gds_pkg::CMD_STEP, 1023, 32'hffffffff, 1023);
        queue_item(gds_pkg::CMD_READ, 1, 0, 0);
        drain(50);
        reg_write(11'd1);
        queue_item(gds_pkg::CMD_STEP, 0, 0, 0);
        queue_item(gds_pkg::CMD_READ, 0, 0, 0);
        drain(50);
        reg_write(11'd0);
        queue_item(gds_pkg::CMD_STEP, 0, 0, 0);
        queue_item(gds_pkg::CMD_READ, 3, 0, 0);
        drain(50);

        // fill the low vertices used by the random phases
        reg_write(11'd16);
        for (int v = 0; v < 16; v++) queue_item(gds_pkg::CMD_LOAD, v, rand_value(), 1023);
        queue_item(gds_pkg::CMD_STEP, 0, 0, 0);
        queue_item(gds_pkg::CMD_READ, $urandom_range(15), 0, 0);
        drain(50);

        // random phases with small vertex counts
        for (int p = 0; p < 7; p++) begin
            n = (p == 0) ? 1 : $urandom_range(2, 16);
            reg_write(11'(n));
            for (int i = 0; i < 22; i++) begin
                r = $urandom_range(99);
                if (r < 40)
                    queue_item(gds_pkg::CMD_LOAD, $urandom_range(1) ? $urandom_range(n - 1)
                               : $urandom_range(1023), rand_value(),
                               $urandom_range(1) ? n : 1023);
                else if (r < 70)
                    queue_item(gds_pkg::CMD_READ, $urandom_range(1) ? $urandom_range(n - 1)
                               : $urandom_range(15), $urandom(), 1023);
                else if (r < 95)
                    queue_item(gds_pkg::CMD_STEP, $urandom_range(1023), $urandom(), 1023);
                else
                    queue_item(gds_pkg::CMD_NONE, $urandom_range(1023), $urandom(), 1023);
            end
            drain(50);
        end

        drain(100);
        if (!failed) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
